[rtl/assert_macros.svh]
// Assertion helper macros for the histogram binner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/llhb_pkg.sv]
// ----------------------------------------------------------------------------
// llhb_pkg
// Types and constants shared by the histogram binner modules.
// ----------------------------------------------------------------------------
package llhb_pkg;

  localparam logic [1:0] CFG_LOWER = 2'd0;
  localparam logic [1:0] CFG_UPPER = 2'd1;
  localparam logic [1:0] CFG_LOG   = 2'd2;
  localparam logic [1:0] CFG_BINS  = 2'd3;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [29:0] LOG10_2_Q30 = 30'd323228497;
  localparam int FRAC_BITS = 20;

  typedef enum logic [3:0] {
    ST_CLEAR,  // clearing sweep after reset
    ST_IDLE,
    ST_BOUNDS, // floor/ceil log10 of bounds
    ST_NORM,   // msb search
    ST_SQR,    // repeated squaring, one per cycle
    ST_MUL,    // log10 scaling multiply
    ST_SCALE,  // (v - min) * n product
    ST_DIV,    // restoring division, one bit a cycle
    ST_FIX,    // sign and clamp
    ST_RD,     // memory read
    ST_WR,     // write back incremented count
    ST_OUT     // result waits
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic bounds;
    logic norm;
    logic sqr;
    logic mul;
    logic scale;
    logic div_step;
    logic fix;
    logic mem_rd;
    logic mem_wr;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic sqr_done;
    logic div_done;
    logic is_read;
    logic is_log;
    logic skip_log; // zero sample or equal exponents
  } sts_t;

  // floor(log10(r/65536)) for r in 1..2^33
  function automatic logic signed [3:0] floor_log10(input logic [33:0] r);
    logic signed [3:0] k;
    k = -4'sd5;
    if (r >= 34'd7)          k = -4'sd4;
    if (r >= 34'd66)         k = -4'sd3;
    if (r >= 34'd656)        k = -4'sd2;
    if (r >= 34'd6554)       k = -4'sd1;
    if (r >= 34'd65536)      k = 4'sd0;
    if (r >= 34'd655360)     k = 4'sd1;
    if (r >= 34'd6553600)    k = 4'sd2;
    if (r >= 34'd65536000)   k = 4'sd3;
    if (r >= 34'd655360000)  k = 4'sd4;
    if (r >= 34'd6553600000) k = 4'sd5;
    return k;
  endfunction

  // ceil(log10(r/65536)) for r in 1..6553600000
  function automatic logic signed [3:0] ceil_log10(input logic [33:0] r);
    logic signed [3:0] k;
    k = 4'sd5;
    if (r <= 34'd655360000) k = 4'sd4;
    if (r <= 34'd65536000)  k = 4'sd3;
    if (r <= 34'd6553600)   k = 4'sd2;
    if (r <= 34'd655360)    k = 4'sd1;
    if (r <= 34'd65536)     k = 4'sd0;
    if (r <= 34'd6553)      k = -4'sd1;
    if (r <= 34'd655)       k = -4'sd2;
    if (r <= 34'd65)        k = -4'sd3;
    if (r <= 34'd6)         k = -4'sd4;
    return k;
  endfunction

endpackage

[rtl/llhb_ctrl.sv]
// ----------------------------------------------------------------------------
// llhb_ctrl
// Sequencer for the histogram binner: clear sweep, mapping steps, update.
// ----------------------------------------------------------------------------
module llhb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  llhb_pkg::sts_t sts,
  output llhb_pkg::cmd_t cmd
);

  llhb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= llhb_pkg::ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      llhb_pkg::ST_CLEAR:  if (sts.clr_done) state_nxt = llhb_pkg::ST_IDLE;
      llhb_pkg::ST_IDLE:   if (in_valid) state_nxt = llhb_pkg::ST_BOUNDS;
      llhb_pkg::ST_BOUNDS: begin
        if (sts.is_read) state_nxt = llhb_pkg::ST_RD;
        else if (sts.is_log) state_nxt = llhb_pkg::ST_NORM;
        else state_nxt = llhb_pkg::ST_SCALE;
      end
      llhb_pkg::ST_NORM:   state_nxt = sts.skip_log ? llhb_pkg::ST_SCALE : llhb_pkg::ST_SQR;
      llhb_pkg::ST_SQR:    if (sts.sqr_done) state_nxt = llhb_pkg::ST_MUL;
      llhb_pkg::ST_MUL:    state_nxt = llhb_pkg::ST_SCALE;
      llhb_pkg::ST_SCALE:  state_nxt = llhb_pkg::ST_DIV;
      llhb_pkg::ST_DIV:    if (sts.div_done) state_nxt = llhb_pkg::ST_FIX;
      llhb_pkg::ST_FIX:    state_nxt = llhb_pkg::ST_RD;
      llhb_pkg::ST_RD:     state_nxt = sts.is_read ? llhb_pkg::ST_OUT : llhb_pkg::ST_WR;
      llhb_pkg::ST_WR:     state_nxt = llhb_pkg::ST_OUT;
      llhb_pkg::ST_OUT:    if (!out_stall) state_nxt = llhb_pkg::ST_IDLE;
      default:             state_nxt = llhb_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall  = (state_r != llhb_pkg::ST_IDLE);
    out_valid = (state_r == llhb_pkg::ST_OUT);
    case (state_r)
      llhb_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
      llhb_pkg::ST_IDLE:   cmd.load = in_valid;
      llhb_pkg::ST_BOUNDS: cmd.bounds = 1'b1;
      llhb_pkg::ST_NORM:   cmd.norm = 1'b1;
      llhb_pkg::ST_SQR:    cmd.sqr = 1'b1;
      llhb_pkg::ST_MUL:    cmd.mul = 1'b1;
      llhb_pkg::ST_SCALE:  cmd.scale = 1'b1;
      llhb_pkg::ST_DIV:    cmd.div_step = 1'b1;
      llhb_pkg::ST_FIX:    cmd.fix = 1'b1;
      llhb_pkg::ST_RD:     cmd.mem_rd = 1'b1;
      llhb_pkg::ST_WR:     cmd.mem_wr = 1'b1;
      default:             ;
    endcase
  end

endmodule

[rtl/llhb_dp.sv]
// ----------------------------------------------------------------------------
// llhb_dp
// Datapath: bounds, log10 by squaring, scaling, divider, bin memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module llhb_dp #(
  parameter int NUM_BINS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  llhb_pkg::cmd_t cmd,
  output llhb_pkg::sts_t sts,
  input  logic [31:0]    lower_bound,
  input  logic [31:0]    upper_bound,
  input  logic           log_scale,
  input  logic [8:0]     bins_in_use,
  input  logic           in_req_type,
  input  logic [31:0]    in_sample,
  input  logic [7:0]     in_read_bin,
  output logic [7:0]     out_bin_index,
  output logic [31:0]    out_bin_total
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int NW = $clog2(NUM_BINS + 1);
  localparam int DW = 72;  // dividend magnitude width

  logic [31:0] mem [NUM_BINS];

  logic          req_r;
  logic [31:0]   smp_r;
  logic [7:0]    rbin_r;
  logic [NW-1:0] n_r;
  logic signed [34:0] lo_r, hi_r;
  logic signed [24:0] minq_r, maxq_r;
  logic          log_r, skip_r;
  logic [4:0]    msb_r;
  logic [32:0]   m_r;
  logic [20:0]   frac_r;
  logic [4:0]    cnt_r;
  logic signed [42:0] l2_r;
  logic signed [35:0] v_r;       // linear or log numerator before scale
  logic signed [35:0] d_r;       // divisor (signed)
  logic [DW-1:0] q_r, rem_r;
  logic [DW-1:0] dvd_r;
  logic [36:0]   dvs_r;
  logic          neg_r;
  logic [6:0]    dcnt_r;
  logic [AW-1:0] clr_r;
  logic          clr_done_r;
  logic [AW-1:0] bin_r;
  logic [31:0]   rd_r;
  logic          oob_r;

  // effective bounds
  logic [33:0] lo_e, hi_e;
  always_comb begin
    lo_e = {2'b0, lower_bound};
    hi_e = (lower_bound == upper_bound) ? ({2'b0, lower_bound} + 34'd65536)
                                        : {2'b0, upper_bound};
    if (log_scale && lo_e == '0) lo_e = 34'd1;
    if (log_scale && hi_e == '0) hi_e = 34'd1;
  end

  // msb search as priority logic over the sample
  logic [4:0] msb_c;
  always_comb begin
    msb_c = '0;
    for (int i = 0; i < 32; i++) if (smp_r[i]) msb_c = 5'(i);
  end

  logic [65:0] sq;
  assign sq = 66'(m_r) * 66'(m_r);
  logic [34:0] sq_s;
  assign sq_s = sq[65:31];

  localparam logic [29:0] LOG10_W = llhb_pkg::LOG10_2_Q30;
  logic [72:0] lmul;
  assign lmul = (l2_r[42] ? 43'(-l2_r) : 43'(l2_r)) * LOG10_W;

  logic [DW:0] rsub;
  assign rsub = {rem_r[DW-2:0], dvd_r[DW-1]} - {{(DW-37){1'b0}}, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_step && !clr_done_r) begin
      clr_r <= clr_r + 1'b1;
      if (32'(clr_r) == NUM_BINS - 1) clr_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step && !clr_done_r) mem[clr_r] <= '0;
    else if (cmd.mem_wr && !oob_r) mem[bin_r] <= (rd_r == '1) ? rd_r : rd_r + 32'd1;
    if (cmd.mem_rd) rd_r <= mem[bin_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      smp_r  <= in_sample;
      rbin_r <= in_read_bin;
      log_r  <= log_scale;
      if (bins_in_use == '0) n_r <= NW'(1);
      else if (32'(bins_in_use) > NUM_BINS) n_r <= NW'(NUM_BINS);
      else n_r <= NW'(bins_in_use);
      lo_r <= 35'(lo_e);
      hi_r <= 35'(hi_e);
    end
    if (cmd.bounds) begin
      minq_r <= 25'(llhb_pkg::floor_log10(34'(lo_r))) <<< llhb_pkg::FRAC_BITS;
      maxq_r <= 25'(llhb_pkg::ceil_log10(34'(hi_r))) <<< llhb_pkg::FRAC_BITS;
      v_r <= 36'($signed({4'b0, smp_r})) - 36'(lo_r);
      d_r <= 36'(hi_r) - 36'(lo_r);
      bin_r  <= AW'(rbin_r);
      oob_r  <= (32'(rbin_r) >= NUM_BINS);
    end
    if (cmd.norm) begin
      skip_r <= (smp_r == '0) || (minq_r == maxq_r);
      msb_r  <= msb_c;
      m_r    <= 33'({1'b0, smp_r} << (5'd31 - msb_c));
      frac_r <= '0;
      cnt_r  <= '0;
      v_r    <= 36'(minq_r);  // scale forces bin 0 when skipped
      d_r    <= (minq_r == maxq_r) ? 36'sd1 : 36'(maxq_r) - 36'(minq_r);
    end
    if (cmd.sqr) begin
      logic        ovf;
      logic [20:0] frac_c;
      ovf    = (sq_s[34:32] != '0);
      frac_c = {frac_r[19:0], ovf};
      cnt_r  <= cnt_r + 5'd1;
      m_r    <= ovf ? sq_s[33:1] : sq_s[32:0];
      frac_r <= frac_c;
      l2_r   <= 43'($signed({1'b0, msb_r})) * 43'sd1048576
              + 43'($signed({1'b0, frac_c})) - 43'sd16777216;
    end
    if (cmd.mul) begin
      logic signed [36:0] lv;
      logic signed [36:0] vc;
      lv = l2_r[42] ? -37'($signed({1'b0, 37'((lmul + 73'h3FFFFFFF) >> 30)}))
                    : 37'($signed({1'b0, 37'(lmul >> 30)}));
      vc = lv;
      if (vc < 37'(minq_r)) vc = 37'(minq_r);
      else if (vc > 37'(maxq_r)) vc = 37'(maxq_r);
      v_r <= 36'(vc) - 36'(minq_r);
      d_r <= 36'(maxq_r) - 36'(minq_r);
    end
    if (cmd.scale) begin
      logic signed [47:0] p;
      if (log_r && skip_r) begin
        p = '0;
        d_r <= 36'sd1;
      end else begin
        p = 48'(v_r) * 48'($signed({1'b0, n_r}));
      end
      neg_r <= p[47] ^ d_r[35];
      dvd_r <= DW'(p[47] ? -p : p);
      dvs_r <= 37'(d_r[35] ? -d_r : d_r);
      rem_r <= '0;
      q_r   <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 7'd1;
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      if (!rsub[DW]) begin
        rem_r <= rsub[DW-1:0];
        q_r <= {q_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DW-2:0], dvd_r[DW-1]};
        q_r <= {q_r[DW-2:0], 1'b0};
      end
    end
    if (cmd.fix && !req_r) begin
      oob_r <= 1'b0;
      if (neg_r || q_r == '0) bin_r <= '0;
      else if (q_r >= DW'(n_r)) bin_r <= AW'(n_r - NW'(1));
      else bin_r <= AW'(q_r);
    end
  end

  // in log mode the sample was ahead in v_r before the skip cut; mul loads it
  assign sts.clr_done = clr_done_r;
  assign sts.sqr_done = (cnt_r == 5'(llhb_pkg::FRAC_BITS - 1));
  assign sts.div_done = (dcnt_r == 7'(DW - 1));
  assign sts.is_read  = req_r;
  assign sts.is_log   = log_r;
  assign sts.skip_log = (smp_r == '0) || (minq_r == maxq_r);

  assign out_bin_index = req_r ? rbin_r : 8'(bin_r);
  assign out_bin_total = req_r ? (oob_r ? 32'd0 : rd_r)
                               : ((rd_r == '1) ? rd_r : rd_r + 32'd1);

  `ASSERT_IMPL(a_wr_no_clr, clk, rst_n, cmd.mem_wr, !cmd.clr_step, "write during clear")
  `ASSERT_IMPL(a_rd_done, clk, rst_n, cmd.mem_rd, clr_done_r, "read before clear done")
  `ASSERT_NEXT(a_bin_rng, clk, rst_n, cmd.fix && !req_r, 32'(bin_r) < NUM_BINS, "bin range")

endmodule

[rtl/linear_log_histogram_binner.sv]
// ----------------------------------------------------------------------------
// linear_log_histogram_binner
// Histogram of Q16.16 samples with linear or base-10 log bins.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// in      | in  | in_valid/stall   | req_type, sample, read_bin
// out     | out | out_valid/stall  | bin_index, bin_total
// cfg     | in  | cfg_valid/ready  | cfg_index, cfg_data
//
// Per word, from accept through result: a read skips the mapping steps, and a
//   log add of a zero sample or with equal exponents skips the squarings;
//   the 72-step restoring divider and the 20 squarings dominate.
// Reset sweeps all NUM_BINS entries of the bin memory to zero, no words taken.
// out stall holds the result; one word in flight at a time.
// ----------------------------------------------------------------------------
module linear_log_histogram_binner #(
  parameter int NUM_BINS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_sample,
  input  logic [7:0]  in_read_bin,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_bin_index,
  output logic [31:0] out_bin_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] lower_r, upper_r;
  logic        log_r;
  logic [8:0]  bins_r;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= 32'd0;
      upper_r <= 32'd65536;
      log_r   <= 1'b0;
      bins_r  <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        llhb_pkg::CFG_LOWER: lower_r <= cfg_data;
        llhb_pkg::CFG_UPPER: upper_r <= cfg_data;
        llhb_pkg::CFG_LOG:   log_r   <= cfg_data[0];
        llhb_pkg::CFG_BINS:  bins_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  llhb_pkg::cmd_t cmd;
  llhb_pkg::sts_t sts;

  llhb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  llhb_dp #(.NUM_BINS(NUM_BINS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .lower_bound(lower_r), .upper_bound(upper_r), .log_scale(log_r),
    .bins_in_use(bins_r),
    .in_req_type, .in_sample, .in_read_bin, .out_bin_index, .out_bin_total
  );

endmodule
